// File: hdl/mfb_pkg.sv
// ----------------------------------------------------------------------------
// mfb_pkg
// Shared types and constants for the mono frame buffer plot/scanout unit.
// ----------------------------------------------------------------------------
package mfb_pkg;

    // default panel geometry
    localparam int DEF_PANEL_WIDTH  = 128;
    localparam int DEF_PANEL_HEIGHT = 296;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // widest store address (1024 px wide x 1024 rows -> 131072 bytes)
    localparam int ADDR_W = 17;

    // stream widths
    localparam int S_TDATA_W = 48;  // 47 bits of fields padded to 6 bytes
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 8;

    // request codes
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_PLOT  = 2'd1;
    localparam logic [1:0] MODE_SCAN  = 2'd2;

    // colour codes
    localparam logic [1:0] COLOR_WHITE = 2'd0;
    localparam logic [1:0] COLOR_BLACK = 2'd1;
    localparam logic [1:0] COLOR_RED   = 2'd2;

    // byte constants
    localparam logic [7:0] BYTE_WHITE    = 8'hFF;
    localparam logic [7:0] BYTE_BLACK    = 8'h00;
    localparam logic [7:0] MASK_MSB      = 8'h80;
    localparam logic [7:0] CMD_PLANE_BW  = 8'h24;
    localparam logic [7:0] CMD_PLANE_RED = 8'h26;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_PLOT,
        OP_SCAN
    } t_op;

    // classified request handed from front to back
    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;     // plot byte address or scan index
        logic [2:0]        bit_sel;  // pixel within byte, 0 = MSB
        logic              set_bit;  // plot: 1 sets, 0 clears
        logic              fill;     // clear: 1 white, 0 black
        logic              plane;    // scan: 1 red plane (inverted)
        logic              lead;     // scan: index 0, command byte first
        logic              oob;      // scan: index beyond store
    } t_cmd;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_CLEAR,
        BS_WRITE,
        BS_CMD,
        BS_DATA
    } t_back_state;

endpackage

// File: hdl/mfb_front.sv
// ----------------------------------------------------------------------------
// mfb_front
// Accepts requests, clips plots, works out store addresses and queues them.
// ----------------------------------------------------------------------------
module mfb_front #(
    parameter int PANEL_WIDTH  = mfb_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = mfb_pkg::DEF_PANEL_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mfb_pkg::S_TDATA_W-1:0] s_axis_tdata,  // pos_x, pos_y, pixel_color, byte_index
    input  logic [mfb_pkg::S_TUSER_W-1:0] s_axis_tuser,  // mode, plane
    output logic                          o_push,
    output mfb_pkg::t_cmd                 o_cmd,
    input  logic                          i_full
);

    localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
    localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int YW          = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;

    logic [1:0]  w_mode;
    logic        w_plane;
    logic [15:0] w_x;
    logic [15:0] w_y;
    logic [1:0]  w_color;
    logic [12:0] w_idx;
    logic        w_in_x;
    logic        w_in_y;
    logic        w_keep;
    logic [AW-1:0] w_pix_addr;
    logic        w_accept;
    mfb_pkg::t_cmd n_cmd;

    logic          r_valid;
    mfb_pkg::t_cmd r_cmd;

    assign w_mode  = s_axis_tuser[1:0];
    assign w_plane = s_axis_tuser[2];
    assign w_x     = s_axis_tdata[15:0];
    assign w_y     = s_axis_tdata[31:16];
    assign w_color = s_axis_tdata[33:32];
    assign w_idx   = s_axis_tdata[46:34];

    assign w_in_x = ({1'b0, w_x} < 17'(PANEL_WIDTH));
    assign w_in_y = ({1'b0, w_y} < 17'(PANEL_HEIGHT));

    // row base plus byte column; only meaningful once clipped
    assign w_pix_addr = AW'(AW'(w_y[YW-1:0]) * AW'(ROW_BYTES)) + AW'(w_x[15:3]);

    always_comb begin
        n_cmd         = '0;
        n_cmd.bit_sel = w_x[2:0];
        n_cmd.set_bit = !(w_color == mfb_pkg::COLOR_BLACK || w_color == mfb_pkg::COLOR_RED);
        n_cmd.fill    = (w_color == mfb_pkg::COLOR_WHITE);
        n_cmd.plane   = w_plane;
        n_cmd.lead    = (w_idx == 13'd0);
        n_cmd.oob     = (32'(w_idx) >= 32'(STORE_BYTES));
        n_cmd.addr    = {{(mfb_pkg::ADDR_W-13){1'b0}}, w_idx};
        w_keep        = 1'b0;
        unique case (w_mode)
            mfb_pkg::MODE_CLEAR: begin
                n_cmd.op = mfb_pkg::OP_CLEAR;
                w_keep   = 1'b1;
            end
            mfb_pkg::MODE_PLOT: begin
                n_cmd.op   = mfb_pkg::OP_PLOT;
                n_cmd.addr = mfb_pkg::ADDR_W'(w_pix_addr);
                w_keep     = w_in_x && w_in_y;
            end
            mfb_pkg::MODE_SCAN: begin
                n_cmd.op = mfb_pkg::OP_SCAN;
                w_keep   = 1'b1;
            end
            default: begin
                // unused mode: dropped
                n_cmd.op = mfb_pkg::OP_SCAN;
                w_keep   = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = !r_valid || !i_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_push        = r_valid && !i_full;
    assign o_cmd         = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= w_keep;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// File: hdl/mfb_queue.sv
// ----------------------------------------------------------------------------
// mfb_queue
// Short request queue decoupling front and back.
// ----------------------------------------------------------------------------
module mfb_queue #(
    parameter int DEPTH = mfb_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mfb_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output mfb_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mfb_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_cnt;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    assign n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// File: hdl/mfb_back.sv
// ----------------------------------------------------------------------------
// mfb_back
// Frame store and sequencer: clear sweep, pixel read-modify-write, scanout.
// ----------------------------------------------------------------------------
module mfb_back #(
    parameter int PANEL_WIDTH  = mfb_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = mfb_pkg::DEF_PANEL_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mfb_pkg::t_cmd                 i_cmd,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mfb_pkg::M_TDATA_W-1:0] m_axis_tdata,  // out_byte
    output logic [0:0]                    m_axis_tuser,  // is_data
    output logic                          m_axis_tlast   // last
);

    localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
    localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    logic [7:0]            r_mem [STORE_BYTES];
    mfb_pkg::t_back_state  r_state;
    mfb_pkg::t_back_state  n_state;
    mfb_pkg::t_cmd         r_cmd;
    logic [AW-1:0]         r_cnt;
    logic [7:0]            r_rd_data;
    logic                  r_out_valid;
    logic [7:0]            r_out_byte;
    logic                  r_out_is_data;
    logic                  r_out_last;

    logic       w_out_free;
    logic       w_sweep_end;
    logic [7:0] w_mask;
    logic       w_rd_en;
    logic       w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [7:0] w_wr_data;
    logic       w_out_load;
    logic [7:0] w_out_byte;
    logic       w_out_is_data;
    logic       w_out_last;

    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_sweep_end = (r_cnt == AW'(STORE_BYTES - 1));
    assign w_mask      = mfb_pkg::MASK_MSB >> r_cmd.bit_sel;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mfb_pkg::BS_IDLE: begin
                if (!i_empty) begin
                    unique case (i_cmd.op)
                        mfb_pkg::OP_CLEAR: n_state = mfb_pkg::BS_CLEAR;
                        mfb_pkg::OP_PLOT:  n_state = mfb_pkg::BS_WRITE;
                        default:           n_state = i_cmd.lead ? mfb_pkg::BS_CMD
                                                                : mfb_pkg::BS_DATA;
                    endcase
                end
            end
            mfb_pkg::BS_CLEAR: begin
                if (w_sweep_end) begin
                    n_state = mfb_pkg::BS_IDLE;
                end
            end
            mfb_pkg::BS_WRITE: n_state = mfb_pkg::BS_IDLE;
            mfb_pkg::BS_CMD: begin
                if (w_out_free) begin
                    n_state = mfb_pkg::BS_DATA;
                end
            end
            mfb_pkg::BS_DATA: begin
                if (w_out_free) begin
                    n_state = mfb_pkg::BS_IDLE;
                end
            end
            default: n_state = mfb_pkg::BS_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_pop         = 1'b0;
        w_rd_en       = 1'b0;
        w_wr_en       = 1'b0;
        w_wr_addr     = r_cmd.addr[AW-1:0];
        w_wr_data     = r_rd_data | w_mask;
        w_out_load    = 1'b0;
        w_out_byte    = r_cmd.plane ? mfb_pkg::CMD_PLANE_RED : mfb_pkg::CMD_PLANE_BW;
        w_out_is_data = 1'b0;
        w_out_last    = 1'b0;
        unique case (r_state)
            mfb_pkg::BS_IDLE: begin
                o_pop   = !i_empty;
                w_rd_en = !i_empty && (i_cmd.op != mfb_pkg::OP_CLEAR);
            end
            mfb_pkg::BS_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_cnt;
                w_wr_data = r_cmd.fill ? mfb_pkg::BYTE_WHITE : mfb_pkg::BYTE_BLACK;
            end
            mfb_pkg::BS_WRITE: begin
                w_wr_en   = 1'b1;
                w_wr_data = r_cmd.set_bit ? (r_rd_data | w_mask) : (r_rd_data & ~w_mask);
            end
            mfb_pkg::BS_CMD: begin
                w_out_load = w_out_free;
            end
            mfb_pkg::BS_DATA: begin
                w_out_load    = w_out_free;
                w_out_byte    = (r_cmd.oob ? mfb_pkg::BYTE_BLACK : r_rd_data)
                                ^ {8{r_cmd.plane}};
                w_out_is_data = 1'b1;
                w_out_last    = 1'b1;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mfb_pkg::BS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == mfb_pkg::BS_CLEAR) begin
            r_cnt <= r_cnt + 1'b1;
        end else begin
            r_cnt <= '0;
        end
        if (w_out_load) begin
            r_out_byte    <= w_out_byte;
            r_out_is_data <= w_out_is_data;
            r_out_last    <= w_out_last;
        end
    end

    // frame store
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[i_cmd.addr[AW-1:0]];
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_byte;
    assign m_axis_tuser[0] = r_out_is_data;
    assign m_axis_tlast    = r_out_last;

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!i_empty && r_state == mfb_pkg::BS_IDLE))
        else $error("request taken while back end busy");

    a_sweep_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mfb_pkg::BS_CLEAR) |-> ({1'b0, r_cnt} < (AW+1)'(STORE_BYTES)))
        else $error("clear sweep beyond store");

    a_no_write_on_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mfb_pkg::BS_CMD || r_state == mfb_pkg::BS_DATA) |-> !w_wr_en)
        else $error("store written during scanout");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && w_out_last) |=> (r_state == mfb_pkg::BS_IDLE))
        else $error("final byte sent without returning to idle");

endmodule

// File: hdl/mono_framebuffer_plot_and_scanout_unit.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_plot_and_scanout_unit
// 1 bpp frame store with clear, pixel plot and byte scanout towards a panel.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests arrive on the s_axis channel: tuser carries mode and plane,
//    tdata the coordinates, colour and scanout byte index.
//  - Results leave on m_axis: tdata is the byte, tuser[0] is 1 for data and
//    0 for a command byte, tlast marks the final byte of a request.
//  - Clear and plot give no result. Scanout gives one data byte, preceded by
//    the plane command byte (0x24 / 0x26) when the index is 0.
//  - Plots outside the panel and the unused mode are dropped in the front.
//  - Front stage registers and classifies; a two-deep queue feeds the back
//    end, which owns the single-port frame store.
//  - Back end: plot reads the byte, then writes it back; scanout reads the
//    byte, then sends each byte in turn; clear writes one byte per cycle
//    over the store. A new request is taken only once back in idle.
//  - The first scanout byte passes the front register, the queue, the store
//    read and the output register on its way to m_axis.
//  - The store contents are undefined after reset until cleared; reset clears
//    the front register, queue and output register and idles the back end.
//  - A stalled m_axis holds the back end; the queue then fills and s_axis
//    tready drops.
// ----------------------------------------------------------------------------
module mono_framebuffer_plot_and_scanout_unit #(
    parameter int PANEL_WIDTH  = mfb_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = mfb_pkg::DEF_PANEL_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mfb_pkg::S_TDATA_W-1:0] s_axis_tdata,  // pos_x[15:0], pos_y[31:16],
                                                          // pixel_color[33:32],
                                                          // byte_index[46:34], pad[47]
    input  logic [mfb_pkg::S_TUSER_W-1:0] s_axis_tuser,  // mode[1:0], plane[2]
    // result channel
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mfb_pkg::M_TDATA_W-1:0] m_axis_tdata,  // out_byte[7:0]
    output logic [0:0]                    m_axis_tuser,  // is_data[0]
    output logic                          m_axis_tlast   // last
);

    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_empty;
    mfb_pkg::t_cmd w_front_cmd;
    mfb_pkg::t_cmd w_queue_cmd;

    // classify and address
    mfb_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_push        (w_push),
        .o_cmd         (w_front_cmd),
        .i_full        (w_full)
    );

    // decoupling queue
    mfb_queue #(
        .DEPTH (mfb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_queue_cmd),
        .o_empty (w_empty)
    );

    // store and sequencer
    mfb_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_queue_cmd),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: sim/mono_framebuffer_plot_and_scanout_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_plot_and_scanout_unit_tb
// Self-checking bench for the 1 bpp frame store unit. A scripted opening covers
// reset, clears of each colour, clipping and the command byte at index 0. A
// long random run of plots, scans and clears follows. Every result byte is
// checked against typed bytes or a store copy, and both streams stall at random.
// ----------------------------------------------------------------------------
module mono_framebuffer_plot_and_scanout_unit_tb;

    localparam int ROW_BYTES    = (mfb_pkg::DEF_PANEL_WIDTH + 7) / 8;
    localparam int STORE_BYTES  = ROW_BYTES * mfb_pkg::DEF_PANEL_HEIGHT;
    localparam int RANDOM_ITEMS = 1850;
    localparam int CLEAR_BUDGET = 40;      // each clear costs a full store walk
    localparam int CYCLE_LIMIT  = 2_000_000;

    localparam logic [1:0] MODE_UNUSED = 2'd3;   // ignored by the block
    localparam logic [1:0] COLOR_SPARE = 2'd3;   // behaves as white on plot

    // one request as the fields are defined, before packing onto the bus
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [1:0]  color;
        logic        plane;
        logic [12:0] byte_index;
    } t_request;

    // one byte expected on the result stream
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_data;
        logic       last;
    } t_panel_byte;

    // scripted row: typed rows carry their expected bytes, the rest use the store copy
    typedef struct packed {
        t_request   req;
        logic       typed;
        logic [1:0] n_typed;
        logic [7:0] cmd_typed;
        logic [7:0] data_typed;
    } t_script_row;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;  // pos_x, pos_y, pixel_color, byte_index, pad
    logic [2:0]  s_axis_tuser  = '0;  // mode, plane
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // out_byte
    logic [0:0]  m_axis_tuser;        // is_data
    logic        m_axis_tlast;

    // bench state
    logic [7:0]    store_copy [STORE_BYTES];  // what the frame store should hold
    t_panel_byte   panel_bytes_due [$];       // bytes still to come, oldest first
    t_panel_byte   head;
    t_script_row   script [$];
    int            fail_cnt   = 0;
    int            cycle_cnt  = 0;
    int            stall_left = 0;
    bit            idle_on    = 1'b1;         // random gaps on both streams

    mono_framebuffer_plot_and_scanout_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Store copy: applies one request and returns the bytes it should produce.
    // ------------------------------------------------------------------------
    function automatic int apply_request(input t_request req, output t_panel_byte due [2]);
        int         n;
        int         addr;
        logic [7:0] mask;
        logic [7:0] val;
        n = 0;
        due[0] = '0;
        due[1] = '0;
        case (req.mode)
            mfb_pkg::MODE_CLEAR: begin
                for (int i = 0; i < STORE_BYTES; i++)
                    store_copy[i] = (req.color == mfb_pkg::COLOR_WHITE) ? mfb_pkg::BYTE_WHITE
                                                                        : mfb_pkg::BYTE_BLACK;
            end
            mfb_pkg::MODE_PLOT: begin
                // off-panel plots are clipped away
                if (int'(req.pos_x) < mfb_pkg::DEF_PANEL_WIDTH &&
                    int'(req.pos_y) < mfb_pkg::DEF_PANEL_HEIGHT) begin
                    addr = int'(req.pos_y) * ROW_BYTES + int'(req.pos_x) / 8;
                    mask = mfb_pkg::MASK_MSB >> req.pos_x[2:0];
                    if (req.color == mfb_pkg::COLOR_BLACK || req.color == mfb_pkg::COLOR_RED)
                        store_copy[addr] = store_copy[addr] & ~mask;
                    else
                        store_copy[addr] = store_copy[addr] | mask;
                end
            end
            mfb_pkg::MODE_SCAN: begin
                // beyond the store reads as all black, before the red inversion
                val = (int'(req.byte_index) < STORE_BYTES) ? store_copy[req.byte_index]
                                                           : mfb_pkg::BYTE_BLACK;
                if (req.plane)
                    val = ~val;
                if (req.byte_index == '0) begin
                    due[n] = '{req.plane ? mfb_pkg::CMD_PLANE_RED : mfb_pkg::CMD_PLANE_BW,
                               1'b0, 1'b0};
                    n++;
                end
                due[n] = '{val, 1'b1, 1'b1};
                n++;
            end
            default: ;
        endcase
        return n;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    function automatic t_request mk_request(input logic [1:0] mode, input int x, input int y,
                                            input logic [1:0] color, input logic plane,
                                            input int idx);
        t_request r;
        r.mode       = mode;
        r.pos_x      = 16'(x);
        r.pos_y      = 16'(y);
        r.color      = color;
        r.plane      = plane;
        r.byte_index = 13'(idx);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: presents one request, waits for the handshake, records
    // the expected bytes, then maybe idles. tvalid stays high across
    // back-to-back requests.
    // ------------------------------------------------------------------------
    task automatic send_request(input t_script_row row);
        t_panel_byte due [2];
        int          n;
        int          gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, row.req.byte_index, row.req.color,
                          row.req.pos_y, row.req.pos_x};
        s_axis_tuser  <= {row.req.plane, row.req.mode};
        do @(posedge i_clk); while (!s_axis_tready);
        n = apply_request(row.req, due);
        if (row.typed) begin
            n = row.n_typed;
            if (n == 2) begin
                due[0] = '{row.cmd_typed, 1'b0, 1'b0};
                due[1] = '{row.data_typed, 1'b1, 1'b1};
            end else begin
                due[0] = '{row.data_typed, 1'b1, 1'b1};
            end
        end
        for (int k = 0; k < n; k++)
            panel_bytes_due.push_back(due[k]);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = pick_gap();
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {1'b0, 47'($urandom_range(0, 32'hFFFF_FFFF))};  // junk while idle
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic script_row(input logic [1:0] mode, input int x, input int y,
                              input logic [1:0] color, input logic plane, input int idx,
                              input logic typed, input int n, input logic [7:0] cmd,
                              input logic [7:0] data);
        script.push_back('{mk_request(mode, x, y, color, plane, idx),
                           typed, 2'(n), cmd, data});
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, then compare with the oldest due byte.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            stall_left    <= pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (panel_bytes_due.size() == 0) begin
                $error("unexpected result: out_byte %0h is_data %0b last %0b",
                       m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
                fail_cnt++;
            end else begin
                head = panel_bytes_due.pop_front();
                if (m_axis_tdata !== head.data_byte) begin
                    $error("out_byte mismatch: expected %0h, got %0h",
                           head.data_byte, m_axis_tdata);
                    fail_cnt++;
                end
                if (m_axis_tuser[0] !== head.is_data) begin
                    $error("is_data mismatch: expected %0b, got %0b",
                           head.is_data, m_axis_tuser[0]);
                    fail_cnt++;
                end
                if (m_axis_tlast !== head.last) begin
                    $error("last mismatch: expected %0b, got %0b", head.last, m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        t_script_row row;
        int          counted;
        int          clears;
        int          r;
        int          pick;

        // scripted opening; the store is only scanned in range after the first clear
        script_row(mfb_pkg::MODE_SCAN, 0, 0, mfb_pkg::COLOR_WHITE, 1'b0, 8191,
                   1, 1, 8'h00, 8'h00);
        script_row(mfb_pkg::MODE_SCAN, 0, 0, mfb_pkg::COLOR_WHITE, 1'b1, STORE_BYTES,
                   1, 1, 8'h00, 8'hFF);
        script_row(mfb_pkg::MODE_PLOT, 0, 0, mfb_pkg::COLOR_BLACK, 1'b0, 0,
                   1, 0, 8'h00, 8'h00);
        script_row(mfb_pkg::MODE_CLEAR, 0, 0, mfb_pkg::COLOR_WHITE, 1'b0, 0,
                   1, 0, 8'h00, 8'h00);
        script_row(mfb_pkg::MODE_SCAN, 0, 0, mfb_pkg::COLOR_WHITE, 1'b0, 0,
                   1, 2, mfb_pkg::CMD_PLANE_BW, 8'hFF);
        script_row(mfb_pkg::MODE_SCAN, 0, 0, mfb_pkg::COLOR_WHITE, 1'b1, 0,
                   1, 2, mfb_pkg::CMD_PLANE_RED, 8'h00);
        script_row(mfb_pkg::MODE_SCAN, 0, 0, mfb_pkg::COLOR_WHITE, 1'b0, STORE_BYTES - 1,
                   1, 1, 8'h00, 8'hFF);
        script_row(mfb_pkg::MODE_PLOT, 0, 0, mfb_pkg::COLOR_BLACK, 1'b0, 0,
                   0, 0, 8'h00, 8'h00);
        script_row(mfb_pkg::MODE_PLOT, 127, 295, mfb_pkg::COLOR_RED, 1'b0, 0,
                   0, 0, 8'h00, 8'h00);
        script_row(mfb_pkg::MODE_PLOT, 7, 0, mfb_pkg::COLOR_BLACK, 1'b0, 0,
                   0, 0, 8'h00, 8'h00);
        script_row(mfb_pkg::MODE_PLOT, 6, 0, mfb_pkg::COLOR_RED, 1'b0, 0,
                   0, 0, 8'h00, 8'h00);
        script_row(mfb_pkg::MODE_PLOT, 7, 0, COLOR_SPARE, 1'b0, 0,
                   0, 0, 8'h00, 8'h00);
        script_row(mfb_pkg::MODE_PLOT, 128, 0, mfb_pkg::COLOR_BLACK, 1'b0, 0,
                   0, 0, 8'h00, 8'h00);
        script_row(mfb_pkg::MODE_PLOT, 0, 296, mfb_pkg::COLOR_BLACK, 1'b0, 0,
                   0, 0, 8'h00, 8'h00);
        script_row(mfb_pkg::MODE_PLOT, 65535, 65535, mfb_pkg::COLOR_BLACK, 1'b0, 0,
                   0, 0, 8'h00, 8'h00);
        script_row(MODE_UNUSED, 65535, 65535, COLOR_SPARE, 1'b1, 8191,
                   1, 0, 8'h00, 8'h00);
        script_row(mfb_pkg::MODE_SCAN, 0, 0, mfb_pkg::COLOR_WHITE, 1'b0, 0,
                   0, 0, 8'h00, 8'h00);
        script_row(mfb_pkg::MODE_SCAN, 0, 0, mfb_pkg::COLOR_WHITE, 1'b1, STORE_BYTES - 1,
                   0, 0, 8'h00, 8'h00);
        script_row(mfb_pkg::MODE_SCAN, 0, 0, mfb_pkg::COLOR_WHITE, 1'b0, ROW_BYTES - 1,
                   0, 0, 8'h00, 8'h00);
        script_row(mfb_pkg::MODE_CLEAR, 0, 0, mfb_pkg::COLOR_BLACK, 1'b0, 0,
                   1, 0, 8'h00, 8'h00);
        script_row(mfb_pkg::MODE_SCAN, 0, 0, mfb_pkg::COLOR_WHITE, 1'b0, 100,
                   1, 1, 8'h00, 8'h00);
        script_row(mfb_pkg::MODE_CLEAR, 0, 0, COLOR_SPARE, 1'b0, 0,
                   1, 0, 8'h00, 8'h00);
        script_row(mfb_pkg::MODE_PLOT, 5, 3, mfb_pkg::COLOR_WHITE, 1'b0, 0,
                   0, 0, 8'h00, 8'h00);
        script_row(mfb_pkg::MODE_SCAN, 0, 0, mfb_pkg::COLOR_WHITE, 1'b1, 3 * ROW_BYTES,
                   0, 0, 8'h00, 8'h00);
        script_row(mfb_pkg::MODE_CLEAR, 0, 0, mfb_pkg::COLOR_RED, 1'b0, 0,
                   1, 0, 8'h00, 8'h00);
        script_row(mfb_pkg::MODE_SCAN, 0, 0, mfb_pkg::COLOR_WHITE, 1'b1, 0,
                   1, 2, mfb_pkg::CMD_PLANE_RED, 8'hFF);

        // reset once at the start
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i])
            send_request(script[i]);

        // random run; idling switches off for every other stretch of 150 counted requests
        counted = 0;
        clears  = 0;
        while (counted < RANDOM_ITEMS) begin
            idle_on = ((counted / 150) % 2) == 0;
            row = '0;
            row.req.pos_x      = 16'($urandom);
            row.req.pos_y      = 16'($urandom);
            row.req.color      = 2'($urandom_range(0, 3));
            row.req.plane      = 1'($urandom_range(0, 1));
            row.req.byte_index = 13'($urandom);
            r = $urandom_range(0, 999);
            if (r < 15 && clears < CLEAR_BUDGET) begin
                row.req.mode = mfb_pkg::MODE_CLEAR;
                clears++;
                counted++;
            end else if (r < 40) begin
                // ignored by the block, so not counted
                row.req.mode = MODE_UNUSED;
            end else if (r < 620) begin
                row.req.mode = mfb_pkg::MODE_PLOT;
                if ($urandom_range(0, 9) != 0) begin
                    row.req.pos_x = 16'($urandom_range(0, mfb_pkg::DEF_PANEL_WIDTH - 1));
                    row.req.pos_y = 16'($urandom_range(0, mfb_pkg::DEF_PANEL_HEIGHT - 1));
                end
                counted++;
            end else begin
                row.req.mode = mfb_pkg::MODE_SCAN;
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    row.req.byte_index = '0;
                else if (pick == 1)
                    row.req.byte_index = 13'($urandom_range(STORE_BYTES, 8191));
                else
                    row.req.byte_index = 13'($urandom_range(0, STORE_BYTES - 1));
                counted++;
            end
            send_request(row);
        end

        s_axis_tvalid <= 1'b0;
        idle_on = 1'b0;
        while (panel_bytes_due.size() != 0)
            @(posedge i_clk);
        // room for a trailing clear walk, and for any stray byte to show up
        repeat (STORE_BYTES + 50) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/mfb_pkg.sv
hdl/mfb_front.sv
hdl/mfb_queue.sv
hdl/mfb_back.sv
hdl/mono_framebuffer_plot_and_scanout_unit.sv
sim/mono_framebuffer_plot_and_scanout_unit_tb.sv
